// ===== rtl/fprqm_pkg.sv =====
// fprqm_pkg: shared constants for the fixed-point requantize multiply unit
// register indexes, rounding mode codes and rounding constants
// no dependencies
package fprqm_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned PROD_W  = 64;
   localparam int unsigned EXP_W   = 6;
   localparam int unsigned SHAMT_W = 5;
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned INDEX_W = 2;

   localparam logic [INDEX_W-1:0] REG_SIGNIFICAND = 2'd0;
   localparam logic [INDEX_W-1:0] REG_EXPONENT    = 2'd1;
   localparam logic [INDEX_W-1:0] REG_ROUNDING    = 2'd2;

   localparam logic [MODE_W-1:0] MODE_UPWARD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NEAREST   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HIGH_HALF = 2'd2;

   localparam logic [PROD_W-1:0] NUDGE_POS   = 64'h0000_0000_4000_0000;
   localparam logic [PROD_W-1:0] NUDGE_NEG   = 64'hFFFF_FFFF_C000_0001;
   localparam logic [PROD_W-1:0] TRUNC_BIAS  = 64'h0000_0000_7FFF_FFFF;
   localparam logic [PROD_W-1:0] SAT_PRODUCT = 64'h4000_0000_0000_0000;
   localparam logic [DATA_W-1:0] INT_MIN     = 32'h8000_0000;
   localparam logic [DATA_W-1:0] INT_MAX     = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;
   localparam logic [EXP_W-1:0]  BASE_SHIFT  = 6'd31;
   localparam logic [EXP_W-1:0]  HALF_SHIFT  = 6'd30;
   localparam logic [EXP_W-1:0]  FULL_SHIFT  = 6'd32;

endpackage

// ===== rtl/fixed_point_requantize_multiply_unit.sv =====
// fixed_point_requantize_multiply_unit: six-stage requantizing multiplier
// multiply by a q31 significand, power-of-two scaling and three rounding modes
// depends on fprqm_pkg
//
//   channel   handshake               payload
//   request   start, busy             req_in_value
//   result    rsp_strobe              rsp_out_value
//   csr       csr_valid, csr_ready    csr_index, csr_wdata
//
// one request per cycle, each result passing through the stages in order:
// capture, 32x32 multiply, left shift, 64-bit rounding add,
// 64-bit right shift, 32-bit rounding shift
// busy is always low and csr_ready always high
// reset clears the valid bits and the configuration registers
module fixed_point_requantize_multiply_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [fprqm_pkg::DATA_W-1:0]   req_in_value,
   output logic                                  rsp_strobe,
   output logic signed [fprqm_pkg::DATA_W-1:0]   rsp_out_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic        [fprqm_pkg::INDEX_W-1:0]  csr_index,
   input  logic        [fprqm_pkg::DATA_W-1:0]   csr_wdata
);

   // configuration
   logic signed [fprqm_pkg::DATA_W-1:0] sig_ff;
   logic        [fprqm_pkg::EXP_W-1:0]  exp_ff;
   logic        [fprqm_pkg::MODE_W-1:0] mode_ff;

   logic                                 exp_pos;
   logic        [fprqm_pkg::SHAMT_W-1:0] lsh;
   logic        [fprqm_pkg::EXP_W-1:0]   rsh;
   logic        [fprqm_pkg::EXP_W-1:0]   tsh;
   logic                                 high_half;
   logic                                 nearest;

   // pipeline
   logic                                 a_valid_ff, b_valid_ff, c_valid_ff;
   logic                                 d_valid_ff, e_valid_ff, rsp_strobe_ff;
   logic signed [fprqm_pkg::DATA_W-1:0]  a_x_ff;
   logic signed [fprqm_pkg::PROD_W-1:0]  b_prod_ff, b_prod_in;
   logic                                 b_sat_ff, b_sat_in;
   logic        [fprqm_pkg::PROD_W-1:0]  c_p_ff, c_p_in;
   logic                                 c_sat_ff;
   logic        [fprqm_pkg::PROD_W-1:0]  d_sum_ff, d_sum_in;
   logic                                 d_sat_ff;
   logic        [fprqm_pkg::DATA_W-1:0]  e_val_ff, e_val_in;
   logic        [fprqm_pkg::DATA_W-1:0]  rsp_value_ff, rsp_value_in;

   logic        [fprqm_pkg::PROD_W-1:0]  half64;
   logic        [fprqm_pkg::PROD_W-1:0]  rnd64;
   logic        [fprqm_pkg::PROD_W-1:0]  trunc64;
   logic signed [fprqm_pkg::PROD_W-1:0]  q64;
   logic signed [fprqm_pkg::PROD_W-1:0]  shr64;
   logic        [fprqm_pkg::SHAMT_W-1:0] rsh_m1;
   logic        [fprqm_pkg::DATA_W-1:0]  half32;
   logic        [fprqm_pkg::DATA_W-1:0]  rnd32;
   logic signed [fprqm_pkg::DATA_W-1:0]  sum32;

   assign busy          = 1'b0;
   assign csr_ready     = 1'b1;
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_out_value = rsp_value_ff;

   assign exp_pos   = !exp_ff[fprqm_pkg::EXP_W-1] && (exp_ff != '0);
   assign lsh       = exp_pos ? exp_ff[fprqm_pkg::SHAMT_W-1:0] : '0;
   assign rsh       = exp_pos ? '0 : (~exp_ff + 6'd1);
   assign tsh       = fprqm_pkg::BASE_SHIFT + rsh;
   assign high_half = (mode_ff == fprqm_pkg::MODE_HIGH_HALF);
   assign nearest   = (mode_ff == fprqm_pkg::MODE_NEAREST);

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_ff  <= '0;
         exp_ff  <= '0;
         mode_ff <= fprqm_pkg::MODE_UPWARD;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fprqm_pkg::REG_SIGNIFICAND: sig_ff  <= csr_wdata;
            fprqm_pkg::REG_EXPONENT:    exp_ff  <= csr_wdata[fprqm_pkg::EXP_W-1:0];
            fprqm_pkg::REG_ROUNDING:    mode_ff <= csr_wdata[fprqm_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // stage b: multiply and saturation detect on the scaled input
   always_comb begin
      b_prod_in = a_x_ff * sig_ff;
      b_sat_in  = (sig_ff == fprqm_pkg::INT_MIN) &&
                  (a_x_ff == (fprqm_pkg::ALL_ONES << (5'd31 - lsh)));
   end

   // stage c: left scaling
   assign c_p_in = b_prod_ff << lsh;

   // stage d: rounding offset
   always_comb begin
      half64 = 64'd1 << (fprqm_pkg::HALF_SHIFT + rsh);
      if (high_half) begin
         rnd64 = c_p_ff[fprqm_pkg::PROD_W-1] ? fprqm_pkg::NUDGE_NEG : fprqm_pkg::NUDGE_POS;
      end else if (nearest && c_p_ff[fprqm_pkg::PROD_W-1]) begin
         rnd64 = half64 - 64'd1;
      end else begin
         rnd64 = half64;
      end
      d_sum_in = c_p_ff + rnd64;
   end

   // stage e: high half or final right shift
   always_comb begin
      trunc64 = d_sum_ff[fprqm_pkg::PROD_W-1] ? (d_sum_ff + fprqm_pkg::TRUNC_BIAS) : d_sum_ff;
      q64     = $signed(trunc64) >>> 31;
      shr64   = $signed(d_sum_ff) >>> tsh;
      if (high_half) begin
         e_val_in = d_sat_ff ? fprqm_pkg::INT_MAX : q64[fprqm_pkg::DATA_W-1:0];
      end else begin
         e_val_in = shr64[fprqm_pkg::DATA_W-1:0];
      end
   end

   // stage f: rounding right shift in 32 bits
   always_comb begin
      rsh_m1 = 5'(rsh - 6'd1);
      half32 = 32'd1 << rsh_m1;
      rnd32  = e_val_ff[fprqm_pkg::DATA_W-1] ? (half32 - 32'd1) : half32;
      sum32  = e_val_ff + rnd32;
      if (!high_half || (rsh == '0)) begin
         rsp_value_in = e_val_ff;
      end else if (rsh >= fprqm_pkg::FULL_SHIFT) begin
         rsp_value_in = {fprqm_pkg::DATA_W{sum32[fprqm_pkg::DATA_W-1]}};
      end else begin
         rsp_value_in = sum32 >>> rsh[fprqm_pkg::SHAMT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         c_valid_ff    <= 1'b0;
         d_valid_ff    <= 1'b0;
         e_valid_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         a_valid_ff    <= start && !busy;
         b_valid_ff    <= a_valid_ff;
         c_valid_ff    <= b_valid_ff;
         d_valid_ff    <= c_valid_ff;
         e_valid_ff    <= d_valid_ff;
         rsp_strobe_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_x_ff       <= req_in_value;
      b_prod_ff    <= b_prod_in;
      b_sat_ff     <= b_sat_in;
      c_p_ff       <= c_p_in;
      c_sat_ff     <= b_sat_ff;
      d_sum_ff     <= d_sum_in;
      d_sat_ff     <= c_sat_ff;
      e_val_ff     <= e_val_in;
      rsp_value_ff <= rsp_value_in;
   end

`ifndef NO_ASSERTIONS
   a_result_follows_request : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 6))
      else $error("result without matching request");

   a_sat_product : assert property (@(posedge clock) disable iff (reset)
      c_valid_ff && c_sat_ff |-> (c_p_ff == fprqm_pkg::SAT_PRODUCT))
      else $error("saturation flag without saturating product");

   a_high_half_pass : assert property (@(posedge clock) disable iff (reset)
      e_valid_ff && high_half && (rsh == '0) |=> (rsp_out_value == $past(e_val_ff)))
      else $error("high half result altered without right shift");

   a_sat_output : assert property (@(posedge clock) disable iff (reset)
      d_valid_ff && d_sat_ff && high_half |=> (e_val_ff == fprqm_pkg::INT_MAX))
      else $error("saturated high half not clamped");
`endif

endmodule
